@@ rtl/core/telemetry_frame_builder_macros.svh @@
// Assertion macros for the telemetry frame builder.
`ifndef TELEMETRY_FRAME_BUILDER_MACROS_SVH
`define TELEMETRY_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define TFB_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define TFB_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/tfb_pkg.sv @@
// Shared types and constants of the telemetry frame builder.
package tfb_pkg;

  localparam logic [7:0] FRAME_HEAD  = 8'hAA;
  localparam logic [7:0] DEST_RESET  = 8'hFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // One accepted, non-stray input item as queued for the back end.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] frame_id;
    logic [7:0] payload_len;
    logic       first;
    logic       last;
  } tfb_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tfb_q_status_t;

endpackage

@@ rtl/core/tfb_front.sv @@
// Front end: input handshake, frame tracking and stray byte drop.
module tfb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,
  input  logic                  s_tlast,
  input  logic                  s_tuser,
  input  tfb_pkg::tfb_q_status_t q_status,
  output logic                  push,
  output tfb_pkg::tfb_item_t    item
);
  import tfb_pkg::*;

  logic frame_open;
  logic accept;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  // A byte without first while no frame is open is swallowed.
  assign push = accept && (s_tuser || frame_open);

  assign item.payload_byte = s_tdata[7:0];
  assign item.frame_id     = s_tdata[15:8];
  assign item.payload_len  = s_tdata[23:16];
  assign item.first        = s_tuser;
  assign item.last         = s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
    end else if (accept) begin
      if (s_tuser) begin
        frame_open <= !s_tlast;
      end else if (frame_open && s_tlast) begin
        frame_open <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/tfb_queue.sv @@
// Small flop queue between front and back end.
module tfb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tfb_pkg::tfb_item_t     item_in,
  input  logic                   pop,
  output tfb_pkg::tfb_item_t     item_out,
  output tfb_pkg::tfb_q_status_t status
);
  import tfb_pkg::*;

  tfb_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign item_out     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/tfb_back.sv @@
// Back end: byte sequencer, check accumulators and output register.
module tfb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tfb_pkg::tfb_item_t     item,
  input  tfb_pkg::tfb_q_status_t q_status,
  input  logic [7:0]             dest_address,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);
  import tfb_pkg::*;

  typedef enum logic [6:0] {
    PH_HEAD = 7'b0000001,
    PH_ADDR = 7'b0000010,
    PH_FID  = 7'b0000100,
    PH_LEN  = 7'b0001000,
    PH_DATA = 7'b0010000,
    PH_SUM  = 7'b0100000,
    PH_ADD  = 7'b1000000
  } phase_t;

  phase_t     phase;
  phase_t     cur_phase;
  phase_t     phase_next;
  logic       busy;
  logic [7:0] sum_check;
  logic [7:0] add_check;
  logic [7:0] base_sum;
  logic [7:0] base_add;
  logic [7:0] sum_next;
  logic [7:0] add_next;
  logic [7:0] byte_sel;
  logic       framed;
  logic       final_step;
  logic       out_load;
  logic       go;

  // Idle between items: the head entry picks the entry phase.
  assign cur_phase = busy ? phase : (item.first ? PH_HEAD : PH_DATA);

  assign out_load = !m_tvalid || m_tready;
  assign go       = !q_status.empty && out_load;

  always_comb begin
    byte_sel   = item.payload_byte;
    framed     = 1'b1;
    final_step = 1'b0;
    phase_next = PH_DATA;
    unique case (cur_phase)
      PH_HEAD: begin
        byte_sel   = FRAME_HEAD;
        phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        byte_sel   = dest_address;
        phase_next = PH_FID;
      end
      PH_FID: begin
        byte_sel   = item.frame_id;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        byte_sel   = item.payload_len;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        byte_sel   = item.payload_byte;
        final_step = !item.last;
        phase_next = PH_SUM;
      end
      PH_SUM: begin
        byte_sel   = sum_check;
        framed     = 1'b0;
        phase_next = PH_ADD;
      end
      PH_ADD: begin
        byte_sel   = add_check;
        framed     = 1'b0;
        final_step = 1'b1;
        phase_next = PH_HEAD;
      end
      default: begin
        byte_sel   = item.payload_byte;
        framed     = 1'b0;
        final_step = 1'b1;
        phase_next = PH_HEAD;
      end
    endcase
  end

  // Checks restart on the header byte of every frame.
  assign base_sum = (cur_phase == PH_HEAD) ? 8'h00 : sum_check;
  assign base_add = (cur_phase == PH_HEAD) ? 8'h00 : add_check;
  assign sum_next = base_sum + byte_sel;
  assign add_next = base_add + sum_next;

  assign pop = go && final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_HEAD;
      sum_check <= 8'h00;
      add_check <= 8'h00;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= go;
      end
      if (go) begin
        busy  <= !final_step;
        phase <= phase_next;
        if (framed) begin
          sum_check <= sum_next;
          add_check <= add_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= byte_sel;
      m_tlast <= (cur_phase == PH_ADD);
      m_tuser <= final_step;
    end
  end

endmodule

@@ rtl/core/telemetry_frame_builder.sv @@
// Top level of the telemetry frame builder: front, queue, back, config, checks.
//
// Usage:
//   Input stream s_*: one payload byte per item. s_tuser = first (opens a
//   frame, header 0xAA, address, frame id, length go out ahead of the byte),
//   s_tlast = last (sum check and add check follow the byte). A byte with no
//   first while no frame is open is dropped with no output.
//   Output stream m_*: one framed byte per item. m_tlast marks the add check
//   byte that ends a frame, m_tuser marks the final byte caused by one input.
//   cfg_*: writes dest_address; always ready, write only while idle.
// Path: an accepted item is queued first; its bytes then pass the output register.
// Throughput: the back-end sequencer emits one byte per cycle while the output
//   is not stalled; a middle payload byte yields one output byte, a first byte
//   five and a last byte three, and a one-byte frame yields seven. The 4-entry
//   queue lets the input keep flowing while a header or check burst is in progress.
// Reset: synchronous rst clears the queue, the checks, frame tracking and
//   the output valid; dest_address returns to 0xFF.
// Stall: when m_tready is low the output register holds; the queue fills
//   and s_tready drops only once it is full.
module telemetry_frame_builder (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // payload_byte [7:0], frame_id [15:8], payload_len [23:16]
  input  logic        s_tlast,   // last
  input  logic        s_tuser,   // first
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte [7:0]
  output logic        m_tlast,   // end_of_frame
  output logic        m_tuser,   // last_of_run
  // Configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // dest_address [7:0]
);
  import tfb_pkg::*;

  `include "telemetry_frame_builder_macros.svh"

  tfb_item_t     front_item;
  tfb_item_t     head_item;
  tfb_q_status_t q_status;
  logic          q_push;
  logic          q_pop;
  logic [7:0]    dest_address;

  // Config register: taken any cycle, used only by the header sequencer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address <= DEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dest_address <= cfg_data;
    end
  end

  tfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .q_status (q_status),
    .push     (q_push),
    .item     (front_item)
  );

  tfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (front_item),
    .pop      (q_pop),
    .item_out (head_item),
    .status   (q_status)
  );

  tfb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item         (head_item),
    .q_status     (q_status),
    .dest_address (dest_address),
    .pop          (q_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

  // The add check always closes the run of its input item.
  `TFB_ASSERT_IMP(a_eof_ends_run, m_tvalid && m_tlast, m_tuser, "end of frame without end of run")
  // Front never writes into a full queue.
  `TFB_ASSERT_IMP(a_no_push_full, q_push, !q_status.full, "push into full queue")
  // Back never pops an empty queue.
  `TFB_ASSERT_IMP(a_no_pop_empty, q_pop, !q_status.empty, "pop from empty queue")
  // A pop always leaves a final byte in the output register.
  `TFB_ASSERT_NXT(a_pop_marks_run, q_pop, m_tvalid && m_tuser, "pop without run end on output")

endmodule

@@ sim/tb_telemetry_frame_builder.sv @@
// Testbench for telemetry_frame_builder: directed and random frames against a framing predictor.
`timescale 1ns / 1ps

module tb_telemetry_frame_builder;
  import tfb_pkg::*;

  // One byte of the framed output stream as the checker wants to see it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic       last_of_run;
  } framed_byte_t;

  // Receiver stall patterns, one picked at random whenever rx_cnt[5:0] is zero.
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKS} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // payload_byte [7:0], frame_id [15:8], payload_len [23:16]
  logic        s_tlast;   // last
  logic        s_tuser;   // first
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // out_byte [7:0]
  logic        m_tlast;   // end_of_frame
  logic        m_tuser;   // last_of_run
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;  // dest_address [7:0]

  // Predictor state: our own copy of the register and the running checks.
  logic [7:0] dest_addr_m;
  logic [7:0] run_sum;
  logic [7:0] run_add;
  bit         frame_open_m;

  framed_byte_t framed_expect_q[$];
  framed_byte_t want;
  int         mismatch_count;
  int         bytes_sent;

  // Sender burst control.
  bit         gaps_on;
  int         burst_left;

  // Receiver stall control.
  logic [15:0] rx_cnt;
  rx_mode_t    rx_mode;
  bit          rx_hold;

  telemetry_frame_builder DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Queue one frame byte and fold it into both checks.
  task automatic push_framed(input logic [7:0] b);
    run_sum = run_sum + b;
    run_add = run_add + run_sum;
    framed_expect_q.push_back('{out_byte: b, end_of_frame: 1'b0, last_of_run: 1'b0});
  endtask

  // Expected output for one accepted item.
  task automatic frame_predict(input tfb_item_t it);
    if (it.first) begin
      // a new first drops any open frame without checks
      run_sum      = 8'h00;
      run_add      = 8'h00;
      frame_open_m = 1'b1;
      push_framed(FRAME_HEAD);
      push_framed(dest_addr_m);
      push_framed(it.frame_id);
      push_framed(it.payload_len);
    end else if (!frame_open_m) begin
      return;  // stray byte: dropped, nothing changes
    end
    push_framed(it.payload_byte);
    if (it.last) begin
      // checks cover what was sent, whatever the header length says
      framed_expect_q.push_back('{out_byte: run_sum, end_of_frame: 1'b0, last_of_run: 1'b0});
      framed_expect_q.push_back('{out_byte: run_add, end_of_frame: 1'b1, last_of_run: 1'b0});
      frame_open_m = 1'b0;
    end
    framed_expect_q[$].last_of_run = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Output checker
  // ---------------------------------------------------------------------

  task automatic report(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %02h actual %02h", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (framed_expect_q.size() == 0) begin
        report("unexpected output item, out_byte", 8'h00, m_tdata);
      end else begin
        want = framed_expect_q.pop_front();
        if (m_tdata !== want.out_byte) report("out_byte", want.out_byte, m_tdata);
        if (m_tlast !== want.end_of_frame)
          report("end_of_frame", 8'(want.end_of_frame), 8'(m_tlast));
        if (m_tuser !== want.last_of_run)
          report("last_of_run", 8'(want.last_of_run), 8'(m_tuser));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stalls on its own rotating pattern
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 16'd1;
    if (rx_cnt[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    if (rx_hold) begin
      m_tready <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:     m_tready <= 1'b1;
        RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: m_tready <= (rx_cnt % 5 != 0);
        default:     m_tready <= rx_cnt[3];  // follows bit 3 of rx_cnt
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers (all called at a rising edge, return at one)
  // ---------------------------------------------------------------------

  function automatic tfb_item_t mk_item(input logic [7:0] pb, input logic [7:0] fid,
                                        input logic [7:0] plen, input logic first,
                                        input logic last);
    tfb_item_t it;
    it.payload_byte = pb;
    it.frame_id     = fid;
    it.payload_len  = plen;
    it.first        = first;
    it.last         = last;
    return it;
  endfunction

  // Send one item; valid stays high into the next item unless a gap is due.
  task automatic send_item(input tfb_item_t it);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    s_tdata  <= {it.payload_len, it.frame_id, it.payload_byte};
    s_tuser  <= it.first;
    s_tlast  <= it.last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    frame_predict(it);
    bytes_sent++;
  endtask

  // Hold the sender until every expected byte is out, then let the pipe settle.
  task automatic wait_idle;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (framed_expect_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // Address write; only called with the block idle.
  task automatic write_dest(input logic [7:0] addr);
    cfg_data  <= addr;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    dest_addr_m = addr;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One frame of nbytes payload bytes; closed adds last on the final byte,
  // len_ok writes the true length into the header.
  task automatic send_frame(input int nbytes, input bit closed, input bit len_ok);
    logic [7:0] plen;
    plen = len_ok ? 8'(nbytes) : 8'($urandom_range(0, 255));
    for (int i = 0; i < nbytes; i++)
      send_item(mk_item(8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)),
                        (i == 0) ? plen : 8'($urandom_range(0, 255)),
                        i == 0,
                        closed && (i == nbytes - 1)));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset address in the header; stray bytes with and without last.
  task automatic test_reset_state;
    send_item(mk_item(8'h00, 8'h00, 8'h00, 1'b1, 1'b1));  // one-byte frame, all zero
    send_item(mk_item(8'h5A, 8'h12, 8'h34, 1'b0, 1'b0));  // stray, frame closed
    send_item(mk_item(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1));  // stray with last
    wait_idle();
  endtask

  // Field extremes, length mismatch, first while a frame is open.
  task automatic test_frame_cases;
    send_item(mk_item(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));  // header claims 255 bytes
    send_item(mk_item(8'h00, 8'hA5, 8'h5A, 1'b0, 1'b0));
    send_item(mk_item(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0));
    send_item(mk_item(8'h80, 8'hFF, 8'hFF, 1'b0, 1'b1));
    send_item(mk_item(8'h01, 8'h7F, 8'h01, 1'b0, 1'b0));  // stray after close
    send_item(mk_item(8'h11, 8'h01, 8'h03, 1'b1, 1'b0));  // opened, then abandoned
    send_item(mk_item(8'h22, 8'h00, 8'h00, 1'b0, 1'b0));
    send_item(mk_item(8'h33, 8'h02, 8'h01, 1'b1, 1'b1));  // restarts with fresh checks
    send_item(mk_item(8'hAA, 8'hAA, 8'h00, 1'b1, 1'b0));  // zero length in header
    send_item(mk_item(8'h55, 8'h55, 8'h55, 1'b0, 1'b1));
    wait_idle();
  endtask

  // Address register at both ends and in between.
  task automatic test_dest_address;
    write_dest(8'h00);
    send_item(mk_item(8'h40, 8'h03, 8'h01, 1'b1, 1'b1));
    wait_idle();
    write_dest(8'hFF);
    send_item(mk_item(8'h02, 8'h04, 8'h01, 1'b1, 1'b1));
    wait_idle();
    write_dest(8'h20);
    send_item(mk_item(8'hC3, 8'h20, 8'h02, 1'b1, 1'b0));
    send_item(mk_item(8'h3C, 8'h01, 8'h02, 1'b0, 1'b1));
    wait_idle();
  endtask

  // Back to back items with an always ready receiver.
  task automatic test_full_rate;
    gaps_on = 1'b0;
    rx_hold = 1'b1;
    for (int f = 0; f < 4; f++) send_frame($urandom_range(1, 5), 1'b1, 1'b1);
    send_frame(1, 1'b1, 1'b1);
    wait_idle();
    rx_hold = 1'b0;
    gaps_on = 1'b1;
  endtask

  // Random traffic in phases, a new address per phase; mostly well formed
  // frames, some stray bytes, abandoned frames and wrong lengths.
  task automatic test_random_traffic;
    int phase_start;
    int kind;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       write_dest(8'h00);
        1:       write_dest(8'hFF);
        default: write_dest(8'($urandom_range(0, 255)));
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 25) begin
        kind = $urandom_range(0, 19);
        if (kind < 2)
          send_item(mk_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'b0,
                            1'($urandom_range(0, 1))));
        else if (kind == 2)
          send_frame($urandom_range(1, 4), 1'b0, 1'b1);
        else if (kind == 3)
          send_frame(1, 1'b1, 1'($urandom_range(0, 1)));
        else if (kind == 4)
          send_frame($urandom_range(9, 24), 1'b1, $urandom_range(0, 3) != 0);
        else
          send_frame($urandom_range(1, 8), 1'b1, $urandom_range(0, 3) != 0);
      end
      wait_idle();  // sender held until the output has drained
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    s_tuser      = 1'b0;
    m_tready     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    rx_cnt       = '0;
    rx_mode      = RX_OPEN;
    rx_hold      = 1'b0;
    gaps_on      = 1'b1;
    burst_left   = 0;
    dest_addr_m  = DEST_RESET;
    run_sum      = 8'h00;
    run_add      = 8'h00;
    frame_open_m = 1'b0;
    mismatch_count = 0;
    bytes_sent   = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_frame_cases();
    test_dest_address();
    test_full_rate();
    test_random_traffic();

    // wait_idle above already drained the output and let it settle
    if (mismatch_count == 0) begin
      $display("telemetry_frame_builder test passed");
    end else begin
      $display("telemetry_frame_builder test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("telemetry_frame_builder test failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/tfb_pkg.sv
rtl/core/tfb_front.sv
rtl/core/tfb_queue.sv
rtl/core/tfb_back.sv
rtl/core/telemetry_frame_builder.sv
sim/tb_telemetry_frame_builder.sv
